>>> rtl/ic_pkg.sv
// ----------------------------------------------------------------------------
// ic_pkg: shared types and constants for the inversion counter
// Widths of the transaction fields, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ic_pkg;

    localparam int IC_MAX_ITEMS = 1024;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 32;
    localparam int ITEMS_W      = 17;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_CHECK,
        ST_SEG_CHECK,
        ST_MERGE,
        ST_FINISH
    } ic_state_t;

    // controller to datapath
    typedef struct packed {
        logic store;      // input transaction accepted
        logic init_sort;  // first pass, run width one
        logic next_pass;  // double run width, swap memories
        logic seg_start;  // set up pointers of one merge
        logic merge;      // one merge step
        logic publish;    // load result register, clear set state
    } ic_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pass_more;  // run width below item count
        logic seg_more;   // segment start below item count
        logic seg_last;   // current step writes the final entry of the segment
        logic out_free;   // result register can take a new result
    } ic_status_t;

endpackage

>>> rtl/inversion_counter.sv
// ----------------------------------------------------------------------------
// inversion_counter: merge-sort inversion counter
// Counts pairs i<j with value[i] > value[j] over one set of signed items.
// ----------------------------------------------------------------------------
// usage
//   input channel (value, last, in_valid/in_ready): one element per
//   transaction, last marks the final element of a set. in_ready is high
//   while the block is loading, so loading runs at one element a cycle.
//   elements beyond MAX_ITEMS are dropped and flag overflow.
//   after last, in_ready drops while the merge passes run. each pass checks
//   whether it is needed, sets up each merged segment and moves every
//   element once through the single read/write stream between the two
//   element memories.
//   output channel (inversion_count, items_counted, overflow,
//   out_valid/out_ready): one result transaction per set, held in an output
//   register; loading of the next set starts while it waits to be taken.
//   if the receiver stalls, a finished count waits until the register frees.
//   reset clears the set state and the output valid; the memory contents
//   need no clearing, only entries written in the current set are read.
// ----------------------------------------------------------------------------
module inversion_counter #(
    parameter int MAX_ITEMS = ic_pkg::IC_MAX_ITEMS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // element transactions
    input  logic signed [ic_pkg::VALUE_W-1:0] value,
    input  logic                              last,
    input  logic                              in_valid,
    output logic                              in_ready,
    // result transactions
    output logic [ic_pkg::COUNT_W-1:0]        inversion_count,
    output logic [ic_pkg::ITEMS_W-1:0]        items_counted,
    output logic                              overflow,
    output logic                              out_valid,
    input  logic                              out_ready
);
    import ic_pkg::*;

    ic_cmd_t    cmd;
    ic_status_t status;

    // sequencing: load, passes, segments, result hand-off
    ic_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    // memories, merge pointers, accumulator and result register
    ic_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .value           (value),
        .cmd             (cmd),
        .out_ready       (out_ready),
        .status          (status),
        .out_valid       (out_valid),
        .inversion_count (inversion_count),
        .items_counted   (items_counted),
        .overflow        (overflow)
    );

endmodule

>>> rtl/ic_ctrl.sv
// ----------------------------------------------------------------------------
// ic_ctrl: sequencing state machine
// Walks load, merge passes, merge segments and result hand-off.
// ----------------------------------------------------------------------------
module ic_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               last,
    input  ic_pkg::ic_status_t status,
    output ic_pkg::ic_cmd_t    cmd,
    output logic               in_ready
);
    import ic_pkg::*;

    ic_state_t state_reg;
    ic_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (last)
                    begin
                        cmd.init_sort = 1'b1;
                        state_next    = ST_PASS_CHECK;
                    end
                end
            end
            ST_PASS_CHECK:
            begin
                if (status.pass_more)
                begin
                    state_next = ST_SEG_CHECK;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SEG_CHECK:
            begin
                if (status.seg_more)
                begin
                    cmd.seg_start = 1'b1;
                    state_next    = ST_MERGE;
                end
                else
                begin
                    cmd.next_pass = 1'b1;
                    state_next    = ST_PASS_CHECK;
                end
            end
            ST_MERGE:
            begin
                cmd.merge = 1'b1;
                if (status.seg_last)
                begin
                    state_next = ST_SEG_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

>>> rtl/ic_datapath.sv
// ----------------------------------------------------------------------------
// ic_datapath: element memories, merge pointers and inversion accumulator
// Bottom-up merge that ping-pongs between two memories, one element a cycle.
// ----------------------------------------------------------------------------
module ic_datapath #(
    parameter int MAX_ITEMS = ic_pkg::IC_MAX_ITEMS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [ic_pkg::VALUE_W-1:0] value,
    input  ic_pkg::ic_cmd_t                   cmd,
    input  logic                              out_ready,
    output ic_pkg::ic_status_t                status,
    output logic                              out_valid,
    output logic [ic_pkg::COUNT_W-1:0]        inversion_count,
    output logic [ic_pkg::ITEMS_W-1:0]        items_counted,
    output logic                              overflow
);
    import ic_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam int WW = IW + 2;

    // element memories
    logic [VALUE_W-1:0] mem_a [MAX_ITEMS];
    logic [VALUE_W-1:0] mem_b [MAX_ITEMS];
    logic [VALUE_W-1:0] rd_a_i_reg, rd_a_j_reg, rd_b_i_reg, rd_b_j_reg;

    // set and merge state
    logic [IW-1:0]      fill_reg, fill_next;
    logic               drop_reg, drop_next;
    logic [COUNT_W-1:0] acc_reg, acc_next;
    logic [WW-1:0]      w_reg, w_next;
    logic [WW-1:0]      lo_reg, lo_next;
    logic               parity_reg, parity_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [IW-1:0]      mid_reg, mid_next;
    logic [IW-1:0]      hi_reg, hi_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] count_out_reg;
    logic [ITEMS_W-1:0] items_out_reg;
    logic               ovf_out_reg;

    logic               room;
    logic [VALUE_W-1:0] op_i, op_j, wr_data;
    logic               left_ok, right_ok, greater, take_right;
    logic [IW-1:0]      span;
    logic [WW-1:0]      n_ext, mid_c, hi_c, last_idx;
    logic               a_we, b_we;
    logic [AW-1:0]      a_waddr;

    always_comb
    begin
        room     = fill_reg < IW'(MAX_ITEMS);
        n_ext    = WW'(fill_reg);
        last_idx = n_ext - WW'(1);
        mid_c    = lo_reg + w_reg - WW'(1);
        hi_c     = lo_reg + (w_reg << 1) - WW'(1);
        if (mid_c > last_idx)
        begin
            mid_c = last_idx;
        end
        if (hi_c > last_idx)
        begin
            hi_c = last_idx;
        end

        op_i       = parity_reg ? rd_b_i_reg : rd_a_i_reg;
        op_j       = parity_reg ? rd_b_j_reg : rd_a_j_reg;
        left_ok    = i_reg <= mid_reg;
        right_ok   = j_reg <= hi_reg;
        greater    = $signed(op_i) > $signed(op_j);
        take_right = right_ok && (!left_ok || greater);
        span       = mid_reg - i_reg + IW'(1);
        wr_data    = take_right ? op_j : op_i;

        fill_next      = fill_reg;
        drop_next      = drop_reg;
        acc_next       = acc_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        parity_next    = parity_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.store)
        begin
            if (room)
            begin
                fill_next = fill_reg + IW'(1);
            end
            else
            begin
                drop_next = 1'b1;
            end
        end
        if (cmd.init_sort)
        begin
            w_next      = WW'(1);
            lo_next     = '0;
            parity_next = 1'b0;
        end
        if (cmd.next_pass)
        begin
            w_next      = w_reg << 1;
            lo_next     = '0;
            parity_next = !parity_reg;
        end
        if (cmd.seg_start)
        begin
            i_next   = IW'(lo_reg);
            j_next   = IW'(mid_c) + IW'(1);
            k_next   = IW'(lo_reg);
            mid_next = IW'(mid_c);
            hi_next  = IW'(hi_c);
        end
        if (cmd.merge)
        begin
            k_next = k_reg + IW'(1);
            if (take_right)
            begin
                j_next = j_reg + IW'(1);
                if (left_ok)
                begin
                    acc_next = acc_reg + COUNT_W'(span);
                end
            end
            else
            begin
                i_next = i_reg + IW'(1);
            end
            if (k_reg == hi_reg)
            begin
                lo_next = lo_reg + (w_reg << 1);
            end
        end
        if (cmd.publish)
        begin
            fill_next      = '0;
            drop_next      = 1'b0;
            acc_next       = '0;
            out_valid_next = 1'b1;
        end

        // load writes memory a, merges write the memory not being read
        a_we    = (cmd.store && room) || (cmd.merge && parity_reg);
        b_we    = cmd.merge && !parity_reg;
        a_waddr = cmd.merge ? k_reg[AW-1:0] : fill_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[a_waddr] <= cmd.merge ? wr_data : value;
        end
        if (b_we)
        begin
            mem_b[k_reg[AW-1:0]] <= wr_data;
        end
        rd_a_i_reg <= mem_a[i_next[AW-1:0]];
        rd_a_j_reg <= mem_a[j_next[AW-1:0]];
        rd_b_i_reg <= mem_b[i_next[AW-1:0]];
        rd_b_j_reg <= mem_b[j_next[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            acc_reg       <= '0;
            w_reg         <= '0;
            lo_reg        <= '0;
            parity_reg    <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            acc_reg       <= acc_next;
            w_reg         <= w_next;
            lo_reg        <= lo_next;
            parity_reg    <= parity_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            count_out_reg <= acc_reg;
            items_out_reg <= ITEMS_W'(fill_reg);
            ovf_out_reg   <= drop_reg;
        end
    end

    always_comb
    begin
        status.pass_more = w_reg < n_ext;
        status.seg_more  = lo_reg < n_ext;
        status.seg_last  = k_reg == hi_reg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign inversion_count = count_out_reg;
    assign items_counted   = items_out_reg;
    assign overflow        = ovf_out_reg;

endmodule

>>> rtl/ic_checker.sv
// ----------------------------------------------------------------------------
// ic_checker: port-level checks for the inversion counter
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module ic_checker #(
    parameter int MAX_ITEMS = ic_pkg::IC_MAX_ITEMS
)
(
    input logic                              clk,
    input logic                              rst_n,
    input logic signed [ic_pkg::VALUE_W-1:0] value,
    input logic                              last,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [ic_pkg::COUNT_W-1:0]        inversion_count,
    input logic [ic_pkg::ITEMS_W-1:0]        items_counted,
    input logic                              overflow,
    input logic                              out_valid,
    input logic                              out_ready
);
    import ic_pkg::*;

    logic unused_value;
    assign unused_value = ^value;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inversion_count)
            && $stable(items_counted) && $stable(overflow))
        else $error("result changed while stalled");

    // counting starts once the final element is taken
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("input taken during counting");

    // drops only happen with a full store
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> items_counted == ITEMS_W'(MAX_ITEMS))
        else $error("overflow without full store");

    // item count within capacity and never zero
    a_items_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> items_counted != '0 && items_counted <= ITEMS_W'(MAX_ITEMS))
        else $error("item count out of range");

    // a single element has no pairs
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && items_counted == ITEMS_W'(1) |-> inversion_count == '0)
        else $error("count non-zero for one element");

endmodule

bind inversion_counter ic_checker #(
    .MAX_ITEMS (MAX_ITEMS)
) u_ic_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .value           (value),
    .last            (last),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .inversion_count (inversion_count),
    .items_counted   (items_counted),
    .overflow        (overflow),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
);
